// ----- rtl/median_filter_3x3_macros.svh -----
// ----------------------------------------------------------------------------
// median_filter_3x3 assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_MACROS_SVH
`define MEDIAN_FILTER_3X3_MACROS_SVH

// same-cycle implication
`define MF3_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("mf3 assertion failed");

// next-cycle implication
`define MF3_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("mf3 assertion failed");

`endif

// ----- rtl/mf3_pkg.sv -----
// ----------------------------------------------------------------------------
// mf3_pkg
// Types and constants shared by the 3x3 median filter modules.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int PIX_BITS        = 8;
  localparam int CFG_WIDTH_BITS  = 11;
  localparam int CFG_HEIGHT_BITS = 13;
  localparam int CFG_DATA_BITS   = 13;
  localparam int ROW_BITS        = 12;
  localparam int WIN_SIZE        = 9;

  localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_MIN   = 13'd3;
  localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_LIMIT = 13'd4096;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef logic [PIX_BITS-1:0] pix_t;
  typedef pix_t window_t [WIN_SIZE];

  typedef struct packed {
    logic valid;
    logic last;
  } mf3_tag_t;

endpackage

// ----- rtl/mf3_line_store.sv -----
// ----------------------------------------------------------------------------
// mf3_line_store
// Two row memories sharing one address, registered read, one write per cycle.
// ----------------------------------------------------------------------------
module mf3_line_store
  import mf3_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output pix_t          rd_a,
  output pix_t          rd_b,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pix_t          wr_a,
  input  pix_t          wr_b
);

  pix_t mem_a [DEPTH];
  pix_t mem_b [DEPTH];
  pix_t rd_a_r;
  pix_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_a;
      mem_b[wr_addr] <= wr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem_a[rd_addr];
      rd_b_r <= mem_b[rd_addr];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

// ----- rtl/mf3_median.sv -----
// ----------------------------------------------------------------------------
// mf3_median
// Two-stage median-of-nine compare/exchange network with result register.
// ----------------------------------------------------------------------------
module mf3_median
  import mf3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  mf3_tag_t tag_in,
  input  window_t  win,
  output mf3_tag_t tag_out,
  output pix_t     median
);

  function automatic logic [2*PIX_BITS-1:0] cx(input pix_t a, input pix_t b);
    cx = (b < a) ? {a, b} : {b, a};
  endfunction

  window_t  sa_nxt;
  window_t  sa_r;
  window_t  sb;
  mf3_tag_t ta_r;
  mf3_tag_t to_r;
  pix_t     med_r;

  // stage A: sort each row
  always_comb begin
    sa_nxt = win;
    {sa_nxt[2], sa_nxt[1]} = cx(sa_nxt[1], sa_nxt[2]);
    {sa_nxt[5], sa_nxt[4]} = cx(sa_nxt[4], sa_nxt[5]);
    {sa_nxt[8], sa_nxt[7]} = cx(sa_nxt[7], sa_nxt[8]);
    {sa_nxt[1], sa_nxt[0]} = cx(sa_nxt[0], sa_nxt[1]);
    {sa_nxt[4], sa_nxt[3]} = cx(sa_nxt[3], sa_nxt[4]);
    {sa_nxt[7], sa_nxt[6]} = cx(sa_nxt[6], sa_nxt[7]);
    {sa_nxt[2], sa_nxt[1]} = cx(sa_nxt[1], sa_nxt[2]);
    {sa_nxt[5], sa_nxt[4]} = cx(sa_nxt[4], sa_nxt[5]);
    {sa_nxt[8], sa_nxt[7]} = cx(sa_nxt[7], sa_nxt[8]);
  end

  // stage B: column and diagonal pruning, median lands in slot 4
  always_comb begin
    sb = sa_r;
    {sb[3], sb[0]} = cx(sb[0], sb[3]);
    {sb[8], sb[5]} = cx(sb[5], sb[8]);
    {sb[7], sb[4]} = cx(sb[4], sb[7]);
    {sb[6], sb[3]} = cx(sb[3], sb[6]);
    {sb[4], sb[1]} = cx(sb[1], sb[4]);
    {sb[5], sb[2]} = cx(sb[2], sb[5]);
    {sb[7], sb[4]} = cx(sb[4], sb[7]);
    {sb[2], sb[4]} = cx(sb[4], sb[2]);
    {sb[4], sb[6]} = cx(sb[6], sb[4]);
    {sb[2], sb[4]} = cx(sb[4], sb[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ta_r <= '0;
      to_r <= '0;
    end else if (en) begin
      ta_r <= tag_in;
      to_r <= ta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r  <= sa_nxt;
      med_r <= sb[4];
    end
  end

  assign tag_out = to_r;
  assign median  = med_r;

endmodule

// ----- rtl/median_filter_3x3.sv -----
// ----------------------------------------------------------------------------
// median_filter_3x3
// 3x3 median filter over a raster-order 8-bit pixel stream.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while results are taken, and issues the median
// of each interior pixel's 3x3 neighbourhood once the pixel that completes
// the window has passed the stage-1 register with its line-store read, the
// window register and both median network registers. Border pixels give no
// result; tlast marks the final interior pixel of the frame. Line stores hold
// no reset content, so no clearing pass runs after reset. Width and height
// are clamped to 3..MAX_WIDTH and 3..4096 and should be written while idle.
// ----------------------------------------------------------------------------
`include "median_filter_3x3_macros.svh"

module median_filter_3x3
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // [7:0] pixel
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [7:0]               out_tdata,  // [7:0] median
  output logic                     out_tlast,  // frame_last
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int AW1 = $clog2(MAX_WIDTH + 1);
  localparam int WB  = (CFG_WIDTH_BITS > AW1) ? CFG_WIDTH_BITS : AW1;
  localparam logic [WB-1:0] W_MIN = WB'(3);
  localparam logic [WB-1:0] W_MAX = WB'(MAX_WIDTH);

  logic [CFG_WIDTH_BITS-1:0]  width_r;
  logic [CFG_HEIGHT_BITS-1:0] height_r;
  logic [CW-1:0]              column_count_r;
  logic [ROW_BITS-1:0]        row_count_r;

  logic [WB-1:0]              width_ext;
  logic [WB-1:0]              width_use;
  logic [WB-1:0]              width_last;
  logic [CFG_HEIGHT_BITS-1:0] height_use;
  logic [CFG_HEIGHT_BITS-1:0] height_last;
  logic                       end_col;
  logic                       end_row;
  logic                       en;
  logic                       accept;

  logic                       v1_r;
  logic                       res1_r;
  logic                       last1_r;
  pix_t                       p1_r;
  logic [CW-1:0]              c1_r;
  pix_t                       up1;
  pix_t                       up2;
  logic                       wr_en;

  window_t                    window_r;
  mf3_tag_t                   wtag_r;
  mf3_tag_t                   otag;
  pix_t                       med;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_data[CFG_WIDTH_BITS-1:0];
        CFG_IDX_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    width_ext = WB'(width_r);
    if (width_ext < W_MIN) begin
      width_use = W_MIN;
    end else if (width_ext > W_MAX) begin
      width_use = W_MAX;
    end else begin
      width_use = width_ext;
    end
    if (height_r < HEIGHT_MIN) begin
      height_use = HEIGHT_MIN;
    end else if (height_r > HEIGHT_LIMIT) begin
      height_use = HEIGHT_LIMIT;
    end else begin
      height_use = height_r;
    end
    width_last  = width_use - WB'(1);
    height_last = height_use - CFG_HEIGHT_BITS'(1);
  end

  assign end_col = WB'(column_count_r) >= width_last;
  assign end_row = CFG_HEIGHT_BITS'(row_count_r) >= height_last;

  // whole pipeline moves together; stalls only on a held result
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
    end else if (accept) begin
      if (end_col) begin
        column_count_r <= '0;
        row_count_r    <= end_row ? '0 : row_count_r + 1'b1;
      end else begin
        column_count_r <= column_count_r + 1'b1;
      end
    end
  end

  // stage 1: pixel waits for its line-store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_r    <= in_tdata;
      c1_r    <= column_count_r;
      res1_r  <= (row_count_r >= ROW_BITS'(2)) && (column_count_r >= CW'(2));
      last1_r <= end_col && end_row;
    end
  end

  assign wr_en = en && v1_r;

  mf3_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (column_count_r),
    .rd_a    (up1),
    .rd_b    (up2),
    .wr_en   (wr_en),
    .wr_addr (c1_r),
    .wr_a    (p1_r),
    .wr_b    (up1)
  );

  // stage 2: window shift, newest column on the right
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wtag_r <= '0;
      for (int i = 0; i < WIN_SIZE; i++) begin
        window_r[i] <= '0;
      end
    end else if (en) begin
      wtag_r.valid <= v1_r && res1_r;
      wtag_r.last  <= last1_r;
      if (v1_r) begin
        for (int k = 0; k < 3; k++) begin
          window_r[k*3]     <= window_r[k*3 + 1];
          window_r[k*3 + 1] <= window_r[k*3 + 2];
        end
        window_r[2] <= up2;
        window_r[5] <= up1;
        window_r[8] <= p1_r;
      end
    end
  end

  mf3_median u_median (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .tag_in  (wtag_r),
    .win     (window_r),
    .tag_out (otag),
    .median  (med)
  );

  assign out_tvalid = otag.valid;
  assign out_tlast  = otag.last;
  assign out_tdata  = med;

  `MF3_ASSERT_IMP(a_no_addr_clash, wr_en && accept, c1_r != column_count_r)
  `MF3_ASSERT_NXT(a_frame_wrap, accept && end_col && end_row,
                  column_count_r == '0 && row_count_r == '0)
  `MF3_ASSERT_NXT(a_col_step, accept && !end_col,
                  column_count_r == $past(column_count_r) + 1'b1)

endmodule

// ----- tb/median_filter_3x3_monitor.sv -----
// ----------------------------------------------------------------------------
// median_filter_3x3_monitor
// Watches the pixel, result and register channels of the 3x3 median filter.
// Keeps its own line stores, window and frame counters, works out the median
// and frame-last flag for every accepted pixel that completes a window, and
// compares each accepted result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module median_filter_3x3_monitor
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [7:0]               in_tdata,   // [7:0] pixel
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [7:0]               out_tdata,  // [7:0] median
  input  logic                     out_tlast,  // frame_last
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       mismatches,
  output int                       pending
);

  typedef struct packed {
    pix_t median;
    logic frame_last;
  } median_exp_t;

  logic [CFG_WIDTH_BITS-1:0]  width_reg;
  logic [CFG_HEIGHT_BITS-1:0] height_reg;
  pix_t                       row_above [MAX_WIDTH];
  pix_t                       row_above2 [MAX_WIDTH];
  window_t                    win;
  int unsigned                col_pos;
  int unsigned                row_pos;
  median_exp_t                median_q [$];
  int                         err_count = 0;
  int                         queued = 0;

  assign mismatches = err_count;
  assign pending    = queued;

  function automatic pix_t median_of(input window_t w);
    int below;
    int not_above;
    for (int i = 0; i < WIN_SIZE; i++) begin
      below     = 0;
      not_above = 0;
      for (int j = 0; j < WIN_SIZE; j++) begin
        if (w[j] < w[i]) below++;
        if (w[j] <= w[i]) not_above++;
      end
      if (below <= WIN_SIZE / 2 && not_above > WIN_SIZE / 2) return w[i];
    end
    return '0;
  endfunction

  task automatic slide_window(input pix_t p);
    int unsigned w;
    int unsigned h;
    pix_t        up1;
    pix_t        up2;
    logic        end_col;
    logic        end_row;
    median_exp_t e;
    w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN :
        (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
    up1     = '0;
    up2     = '0;
    end_col = (col_pos >= w - 1);
    end_row = (row_pos >= h - 1);
    if (col_pos < MAX_WIDTH) begin
      up1                  = row_above[col_pos];
      up2                  = row_above2[col_pos];
      row_above2[col_pos]  = up1;
      row_above[col_pos]   = p;
    end
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = p;
    if (row_pos >= 2 && col_pos >= 2) begin
      e.median     = median_of(win);
      e.frame_last = end_col && end_row;
      median_q.push_back(e);
    end
    if (end_col) begin
      col_pos = 0;
      row_pos = end_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic check_result(input pix_t got_median, input logic got_last);
    median_exp_t e;
    if (median_q.size() == 0) begin
      if (err_count < 10)
        $display("unexpected result: median %0d last %0b", got_median, got_last);
      err_count++;
    end else begin
      e = median_q.pop_front();
      if (got_median !== e.median || got_last !== e.frame_last) begin
        if (err_count < 10)
          $display("result mismatch: median exp %0d got %0d, last exp %0b got %0b",
                   e.median, got_median, e.frame_last, got_last);
        err_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above[i]  = '0;
        row_above2[i] = '0;
      end
      for (int i = 0; i < WIN_SIZE; i++) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      median_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_WIDTH) width_reg = cfg_data[CFG_WIDTH_BITS-1:0];
        else height_reg = cfg_data[CFG_HEIGHT_BITS-1:0];
      end
      if (in_tvalid && in_tready) slide_window(in_tdata);
      if (out_tvalid && out_tready) check_result(out_tdata, out_tlast);
    end
    queued = median_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the 3x3 median filter. Programs frame sizes
// (edge and out-of-range values included), streams directed and random
// frames with random gaps on the pixel side and random stalls on the result
// side, and leaves prediction and comparison to the channel monitor.
// ----------------------------------------------------------------------------
module testbench;
  import mf3_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_PIXELS = 200;
  localparam int LINE_MAX      = 1024;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {PIX_ANY, PIX_EXTREME, PIX_NARROW} pix_mode_t;

  logic                     clk;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [7:0]               in_tdata   = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [7:0]               out_tdata;
  logic                     out_tlast;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic                     cfg_index  = CFG_IDX_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data   = '0;
  int                       mismatches;
  int                       pending;

  bit          in_steady   = 1'b0;
  bit          out_steady  = 1'b0;
  int unsigned frame_w     = WIDTH_RESET;
  int unsigned frame_h     = HEIGHT_RESET;
  int unsigned pos_col     = 0;
  int unsigned pos_row     = 0;
  int unsigned pixels_sent = 0;
  int          idle_cycles = 0;

  median_filter_3x3 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  median_filter_3x3_monitor monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic pix_t pick_pixel(input pix_mode_t mode);
    case (mode)
      PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PIX_NARROW:  return pix_t'($urandom_range(126, 129));
      default:     return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // both registers in one burst so cfg_valid stays high between requests
  task automatic set_frame_size(input logic [CFG_DATA_BITS-1:0] w_val,
                                input logic [CFG_DATA_BITS-1:0] h_val);
    int unsigned w;
    int unsigned h;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_WIDTH;
    cfg_data  <= w_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_IDX_HEIGHT;
    cfg_data  <= h_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    w = w_val[CFG_WIDTH_BITS-1:0];
    h = h_val[CFG_HEIGHT_BITS-1:0];
    frame_w = (w < 3) ? 3 : (w > LINE_MAX) ? LINE_MAX : w;
    frame_h = (h < HEIGHT_MIN) ? HEIGHT_MIN : (h > HEIGHT_LIMIT) ? HEIGHT_LIMIT : h;
  endtask

  task automatic push_pixel(input pix_t p);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
    if (pos_col >= frame_w - 1) begin
      pos_col = 0;
      pos_row = (pos_row >= frame_h - 1) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  task automatic push_pixels(input pix_mode_t mode, input int unsigned n);
    repeat (n) push_pixel(pick_pixel(mode));
  endtask

  // sends until the raster position wraps back to the frame origin
  task automatic run_frame(input pix_mode_t mode);
    do push_pixel(pick_pixel(mode));
    while (pos_col != 0 || pos_row != 0);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk);
    while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned mark;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // smallest frame, checkerboards of the two extreme levels
    set_frame_size(3, 3);
    for (int i = 0; i < 9; i++) push_pixel((i % 2) ? 8'hFF : 8'h00);
    for (int i = 0; i < 9; i++) push_pixel((i % 2) ? 8'h00 : 8'hFF);
    drain();

    // sizes clamped from both sides, frames cut short and closed by a shrink
    set_frame_size(13'h1FFF, 13'h0000);
    push_pixels(PIX_ANY, 40);
    drain();
    set_frame_size(13'h0001, 13'h1FFF);
    push_pixels(PIX_EXTREME, 30);
    drain();
    set_frame_size(3, 3);
    run_frame(PIX_ANY);
    drain();

    // size shrunk mid-frame: current column past the new last column
    set_frame_size(10, 8);
    push_pixels(PIX_ANY, 46);
    drain();
    set_frame_size(6, 6);
    run_frame(PIX_ANY);
    drain();

    // height shrunk mid-frame: current row past the new last row
    set_frame_size(8, 8);
    push_pixels(PIX_NARROW, 43);
    drain();
    set_frame_size(8, 4);
    run_frame(PIX_NARROW);

    mark = pixels_sent;
    while (pixels_sent - mark < RANDOM_PIXELS) begin
      if ($urandom_range(0, 2) != 0) begin
        drain();
        case ($urandom_range(0, 5))
          0:       set_frame_size($urandom_range(0, 2), $urandom_range(3, 6));
          1:       set_frame_size($urandom_range(13, 40), $urandom_range(0, 4));
          default: set_frame_size($urandom_range(3, 12), $urandom_range(3, 7));
        endcase
      end
      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      run_frame(pix_mode_t'($urandom_range(0, 2)));
    end

    drain();
    @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- median_filter_3x3.f -----
+incdir+rtl
rtl/mf3_pkg.sv
rtl/mf3_line_store.sv
rtl/mf3_median.sv
rtl/median_filter_3x3.sv
tb/median_filter_3x3_monitor.sv
tb/testbench.sv
